/* rtl/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants, codes and types of the prefix trie counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  // Default sizes
  localparam int DEF_NODES      = 65536;
  localparam int DEF_MAX_WORD   = 64;
  localparam int DEF_ALPHABET   = 26;
  localparam int DEF_COUNT_BITS = 20;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 2;
  localparam int PCOUNT_W = 20;

  // Word length field of a command, wide enough for the largest word limit
  localparam int LEN_W = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_LONG  = 2'd2;

  // One finished word handed from the front to the engine
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] len;
    logic             bank;
  } ptc_cmd_t;

endpackage

`default_nettype wire

/* rtl/ptc_ram.sv */
// ----------------------------------------------------------------------------
// ptc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/ptc_cmdq.sv */
// ----------------------------------------------------------------------------
// ptc_cmdq
// Two-entry queue of finished words between the front and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_cmdq (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  ptc_pkg::ptc_cmd_t   push_cmd,
  input  wire                 pop,
  output logic                full,
  output logic                head_valid,
  output ptc_pkg::ptc_cmd_t   head_cmd
);
  import ptc_pkg::*;

  ptc_cmd_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entry[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/ptc_front.sv */
// ----------------------------------------------------------------------------
// ptc_front
// Collects letters into a two-bank word buffer and queues finished words.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front #(
  parameter int MAX_WORD = ptc_pkg::DEF_MAX_WORD,
  parameter int ALPHABET = ptc_pkg::DEF_ALPHABET,
  localparam int IB   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
  localparam int LW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1,
  localparam int LENB = $clog2(MAX_WORD + 2)
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [ptc_pkg::OP_W-1:0]       op,
  input  wire  [ptc_pkg::LETTER_W-1:0]   letter,
  input  wire                            has_letter,
  input  wire                            last,
  input  wire                            clearing,
  input  wire                            q_full,
  output logic                           q_push,
  output ptc_pkg::ptc_cmd_t              q_cmd,
  output logic                           wb_we,
  output logic [IB:0]                    wb_waddr,
  output logic [LW-1:0]                  wb_wdata
);
  import ptc_pkg::*;

  localparam int NUM_CODES = 2 ** LETTER_W;

  logic [LW-1:0]   letter_mod [NUM_CODES];
  logic [LENB-1:0] wlen;
  logic            bank;
  logic [LENB-1:0] wlen_next;
  logic            accept;

  // Fold letter codes into the alphabet
  for (genvar i = 0; i < NUM_CODES; i++) begin : g_mod
    localparam int R = i % ALPHABET;
    assign letter_mod[i] = LW'(R);
  end

  assign in_stall = clearing || q_full;
  assign accept   = in_valid && !in_stall;

  // Grow the length, saturating one past the limit
  always_comb begin
    wlen_next = wlen;
    if (has_letter && (wlen <= LENB'(MAX_WORD))) begin
      wlen_next = wlen + LENB'(1);
    end
  end

  // Write the letter into the current bank
  assign wb_we    = accept && has_letter && (wlen < LENB'(MAX_WORD));
  assign wb_waddr = {bank, wlen[IB-1:0]};
  assign wb_wdata = letter_mod[letter];

  // Hand the finished word to the queue
  assign q_push   = accept && last;
  assign q_cmd.op   = op;
  assign q_cmd.len  = LEN_W'(wlen_next);
  assign q_cmd.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (last) begin
        wlen <= '0;
        bank <= ~bank;
      end else begin
        wlen <= wlen_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ptc_engine.sv */
// ----------------------------------------------------------------------------
// ptc_engine
// Runs one queued word at a time over the node table: a check walk, an update
// walk for a fitting insert or present erase, then drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_engine #(
  parameter int NODES      = ptc_pkg::DEF_NODES,
  parameter int MAX_WORD   = ptc_pkg::DEF_MAX_WORD,
  parameter int ALPHABET   = ptc_pkg::DEF_ALPHABET,
  parameter int COUNT_BITS = ptc_pkg::DEF_COUNT_BITS,
  localparam int IB   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
  localparam int LW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              q_valid,
  input  ptc_pkg::ptc_cmd_t                q_cmd,
  output logic                             q_pop,
  output logic                             clearing,
  output logic [IB:0]                      wb_raddr,
  input  wire  [LW-1:0]                    wb_rdata,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [ptc_pkg::STATUS_W-1:0]     status,
  output logic                             found,
  output logic [ptc_pkg::PCOUNT_W-1:0]     prefix_count
);
  import ptc_pkg::*;

  localparam int NB         = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LINK_DEPTH = NODES * ALPHABET;
  localparam int LAB        = $clog2(LINK_DEPTH);
  localparam int LENB       = $clog2(MAX_WORD + 2);
  localparam int CB         = COUNT_BITS;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [NB-1:0] ROOT    = NB'(1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WLK  = 4'd3;
  localparam logic [3:0] S_WCH  = 4'd4;
  localparam logic [3:0] S_POST = 4'd5;
  localparam logic [3:0] S_QRD  = 4'd6;
  localparam logic [3:0] S_ECHK = 4'd7;
  localparam logic [3:0] S_UINC = 4'd8;
  localparam logic [3:0] S_ULK  = 4'd9;
  localparam logic [3:0] S_UCH  = 4'd10;
  localparam logic [3:0] S_UEND = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]          state;
  logic [LAB-1:0]      clr;
  logic [NB-1:0]       last_used;
  logic [NB-1:0]       node;
  logic [LENB-1:0]     idx;
  logic [LENB-1:0]     depth;
  logic [LENB-1:0]     len;
  logic [OP_W-1:0]     cur_op;
  logic                bank;
  logic                path_ok;
  logic [LAB-1:0]      laddr;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [PCOUNT_W-1:0] res_pcount;

  logic                link_we;
  logic [LAB-1:0]      link_waddr;
  logic [NB-1:0]       link_wdata;
  logic [LAB-1:0]      link_raddr;
  logic [NB-1:0]       link_rdata;
  logic                pass_we;
  logic [NB-1:0]       pass_waddr;
  logic [CB-1:0]       pass_wdata;
  logic [NB-1:0]       pass_raddr;
  logic [CB-1:0]       pass_rdata;
  logic                end_we;
  logic [NB-1:0]       end_waddr;
  logic [CB-1:0]       end_wdata;
  logic [NB-1:0]       end_raddr;
  logic [CB-1:0]       end_rdata;

  logic [LAB-1:0]      laddr_calc;
  logic [NB-1:0]       alloc_node;
  logic [NB-1:0]       child_next;
  logic                is_erase;
  logic [CB-1:0]       pass_new;
  logic [CB-1:0]       end_new;
  logic                cut;
  logic                pool_over;
  logic                out_free;
  logic [31:0]         pass_wide;

  // Link slot of the current node and the letter just read
  assign laddr_calc = LAB'(32'(node) * 32'(ALPHABET) + 32'(wb_rdata));
  assign alloc_node = last_used + NB'(1);
  assign child_next = (link_rdata == '0) ? alloc_node : link_rdata;
  assign is_erase   = (cur_op == OP_ERASE);

  // Saturating count update
  always_comb begin
    if (is_erase) begin
      pass_new = (pass_rdata == '0) ? '0 : pass_rdata - CB'(1);
      end_new  = (end_rdata == '0) ? '0 : end_rdata - CB'(1);
    end else begin
      pass_new = (pass_rdata == CNT_MAX) ? pass_rdata : pass_rdata + CB'(1);
      end_new  = (end_rdata == CNT_MAX) ? end_rdata : end_rdata + CB'(1);
    end
  end

  assign cut       = is_erase && (idx != '0) && (pass_new == '0);
  assign pool_over = (32'(last_used) + 32'(len) - 32'(depth)) > 32'(NODES - 1);
  assign out_free  = !out_valid || !out_stall;
  assign pass_wide = 32'(pass_rdata);
  assign clearing  = (state == S_CLR);
  assign q_pop     = (state == S_DONE) && out_free;
  assign wb_raddr  = {bank, idx[IB-1:0]};

  // Drive table ports per state
  always_comb begin
    link_we    = 1'b0;
    link_waddr = laddr;
    link_wdata = '0;
    link_raddr = laddr_calc;
    pass_we    = 1'b0;
    pass_waddr = node;
    pass_wdata = pass_new;
    pass_raddr = node;
    end_we     = 1'b0;
    end_waddr  = node;
    end_wdata  = end_new;
    end_raddr  = node;
    unique case (state)
      S_CLR: begin
        link_we    = 1'b1;
        link_waddr = clr;
        pass_we    = 1'b1;
        pass_waddr = clr[NB-1:0];
        pass_wdata = '0;
        end_we     = 1'b1;
        end_waddr  = clr[NB-1:0];
        end_wdata  = '0;
      end
      S_POST: begin
        if (cur_op == OP_INSERT) pass_raddr = ROOT;
      end
      S_ECHK: begin
        pass_raddr = ROOT;
      end
      S_UINC: begin
        pass_we = 1'b1;
        if (cut) begin
          link_we = 1'b1;
        end
      end
      S_UCH: begin
        pass_raddr = child_next;
        if (link_rdata == '0) begin
          link_we    = 1'b1;
          link_wdata = alloc_node;
        end
      end
      S_UEND: begin
        end_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequence the walks
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      last_used <= ROOT;
      out_valid <= 1'b0;
    end else begin
      // Raise the result when it is loaded, drop it once taken
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)  out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + LAB'(1);
          if (clr == LAB'(LINK_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_op     <= q_cmd.op;
            len        <= LENB'(q_cmd.len);
            bank       <= q_cmd.bank;
            idx        <= '0;
            node       <= ROOT;
            res_found  <= 1'b0;
            res_pcount <= '0;
            if (q_cmd.len > LEN_W'(MAX_WORD)) begin
              res_status <= STAT_TOO_LONG;
              state      <= S_DONE;
            end else begin
              res_status <= STAT_DONE;
              state      <= S_WRD;
            end
          end
        end
        S_WRD: begin
          if (idx == len) begin
            path_ok <= 1'b1;
            depth   <= len;
            state   <= S_POST;
          end else begin
            state <= S_WLK;
          end
        end
        S_WLK: begin
          laddr <= laddr_calc;
          state <= S_WCH;
        end
        S_WCH: begin
          if (link_rdata == '0) begin
            path_ok <= 1'b0;
            depth   <= idx;
            state   <= S_POST;
          end else begin
            node  <= link_rdata;
            idx   <= idx + LENB'(1);
            state <= S_WRD;
          end
        end
        S_POST: begin
          unique case (cur_op)
            OP_INSERT: begin
              if (pool_over) begin
                res_status <= STAT_POOL_FULL;
                state      <= S_DONE;
              end else begin
                node  <= ROOT;
                idx   <= '0;
                state <= S_UINC;
              end
            end
            OP_ERASE: state <= path_ok ? S_ECHK : S_DONE;
            default:  state <= path_ok ? S_QRD : S_DONE;
          endcase
        end
        S_QRD: begin
          res_found  <= (cur_op == OP_SEARCH) && (end_rdata != '0);
          res_pcount <= (cur_op == OP_PREFIX) ? pass_wide[PCOUNT_W-1:0] : '0;
          state      <= S_DONE;
        end
        S_ECHK: begin
          if (end_rdata == '0) begin
            state <= S_DONE;
          end else begin
            node  <= ROOT;
            idx   <= '0;
            state <= S_UINC;
          end
        end
        S_UINC: begin
          priority if (cut)  state <= S_DONE;
          else if (idx == len) state <= S_UEND;
          else                 state <= S_ULK;
        end
        S_ULK: begin
          laddr <= laddr_calc;
          state <= S_UCH;
        end
        S_UCH: begin
          if (link_rdata == '0) last_used <= alloc_node;
          node  <= child_next;
          idx   <= idx + LENB'(1);
          state <= S_UINC;
        end
        S_UEND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status       <= res_status;
            found        <= res_found;
            prefix_count <= res_pcount;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ptc_ram #(.WIDTH(NB), .DEPTH(LINK_DEPTH)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ptc_ram #(.WIDTH(CB), .DEPTH(2 ** NB)) u_pass (
    .clk   (clk),
    .we    (pass_we),
    .waddr (pass_waddr),
    .wdata (pass_wdata),
    .raddr (pass_raddr),
    .rdata (pass_rdata)
  );

  ptc_ram #(.WIDTH(CB), .DEPTH(2 ** NB)) u_ends (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (end_wdata),
    .raddr (end_raddr),
    .rdata (end_rdata)
  );

endmodule

`default_nettype wire

/* rtl/prefix_trie_counter.sv */
// ----------------------------------------------------------------------------
// prefix_trie_counter
// Lowercase trie with pass and end counts per node, fed one letter per item.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the link table, one slot a
// cycle, over all NODES*ALPHABET slots (1,703,936 at the defaults); input is
// stalled until it ends. The front takes one letter item per cycle, while the
// queue is not full, into one of two word banks, so the next word can arrive
// while the previous one is being processed. Each word is then run by the
// engine, which reads one table slot per step: the check walk reads, looks up
// and follows each letter; insert and erase add an update walk that counts,
// looks up and follows each letter. The engine and its tables set throughput.
`default_nettype none

module prefix_trie_counter #(
  parameter int NODES      = ptc_pkg::DEF_NODES,
  parameter int MAX_WORD   = ptc_pkg::DEF_MAX_WORD,
  parameter int ALPHABET   = ptc_pkg::DEF_ALPHABET,
  parameter int COUNT_BITS = ptc_pkg::DEF_COUNT_BITS
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [ptc_pkg::OP_W-1:0]       op,
  input  wire  [ptc_pkg::LETTER_W-1:0]   letter,
  input  wire                            has_letter,
  input  wire                            last,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [ptc_pkg::STATUS_W-1:0]   status,
  output logic                           found,
  output logic [ptc_pkg::PCOUNT_W-1:0]   prefix_count
);
  import ptc_pkg::*;

  localparam int IB = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic          clearing;
  logic          q_full;
  logic          q_push;
  ptc_cmd_t      q_cmd_in;
  logic          q_pop;
  logic          q_valid;
  ptc_cmd_t      q_head;
  logic          wb_we;
  logic [IB:0]   wb_waddr;
  logic [LW-1:0] wb_wdata;
  logic [IB:0]   wb_raddr;
  logic [LW-1:0] wb_rdata;

  ptc_front #(.MAX_WORD(MAX_WORD), .ALPHABET(ALPHABET)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .letter     (letter),
    .has_letter (has_letter),
    .last       (last),
    .clearing   (clearing),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd_in),
    .wb_we      (wb_we),
    .wb_waddr   (wb_waddr),
    .wb_wdata   (wb_wdata)
  );

  ptc_ram #(.WIDTH(LW), .DEPTH(2 * (2 ** IB))) u_words (
    .clk   (clk),
    .we    (wb_we),
    .waddr (wb_waddr),
    .wdata (wb_wdata),
    .raddr (wb_raddr),
    .rdata (wb_rdata)
  );

  ptc_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  ptc_engine #(
    .NODES      (NODES),
    .MAX_WORD   (MAX_WORD),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .wb_raddr     (wb_raddr),
    .wb_rdata     (wb_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found        (found),
    .prefix_count (prefix_count)
  );

endmodule

`default_nettype wire

/* sim/prefix_trie_counter_test.sv */
// ----------------------------------------------------------------------------
// prefix_trie_counter_test
// Self-checking bench for the prefix trie counter: words are sent one letter
// per transaction, and a behavioral trie in the bench predicts every result.
// The bench covers directed corner cases and random word traffic under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_trie_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptc_pkg::*;

  localparam int NODES      = DEF_NODES;
  localparam int MAX_WORD   = DEF_MAX_WORD;
  localparam int ALPHABET   = DEF_ALPHABET;
  localparam int COUNT_MAX  = (1 << DEF_COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [PCOUNT_W-1:0] pcount;
  } trie_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = OP_INSERT;
  logic [LETTER_W-1:0] letter = '0;
  logic                has_letter = 1'b0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [PCOUNT_W-1:0] prefix_count;

  // Trie shadow: sparse link table keyed by node and letter, counts keyed by node
  int link_tab[int];
  int pass_cnt[int];
  int end_cnt[int];
  int node_top;
  int word_buf[MAX_WORD];
  int word_len;

  trie_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int results_seen = 0;
  int pool_refusals = 0;
  int long_refusals = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  prefix_trie_counter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .letter(letter), .has_letter(has_letter), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found(found), .prefix_count(prefix_count)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** prefix_trie_counter: FAILED **");
      $finish;
    end
  end

  // Randomize receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Check results; stall and outputs are stable at the falling edge
  always @(negedge clk) begin
    trie_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result, status", status, -1);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report("status", status, want.status);
        if (found !== want.found) report("found", found, want.found);
        if (prefix_count !== want.pcount) report("prefix_count", prefix_count, want.pcount);
      end
    end
  end

  function automatic int child_at(int node, int idx);
    int key;
    key = node * ALPHABET + word_buf[idx];
    return link_tab.exists(key) ? link_tab[key] : 0;
  endfunction

  function automatic int cnt_of(ref int tab[int], input int node);
    return tab.exists(node) ? tab[node] : 0;
  endfunction

  // Follow the word as far as links exist; node 0 when the path breaks
  function automatic int trace_path(output int depth);
    int node;
    int nxt;
    node = 1;
    for (int i = 0; i < word_len; i++) begin
      nxt = child_at(node, i);
      if (nxt == 0) begin
        depth = i;
        return 0;
      end
      node = nxt;
    end
    depth = word_len;
    return node;
  endfunction

  function automatic bit word_present();
    int depth;
    int node;
    node = trace_path(depth);
    return node != 0 && cnt_of(end_cnt, node) != 0;
  endfunction

  function automatic void bump(ref int tab[int], input int node);
    int v;
    v = cnt_of(tab, node);
    if (v < COUNT_MAX) tab[node] = v + 1;
  endfunction

  function automatic void drop(ref int tab[int], input int node);
    int v;
    v = cnt_of(tab, node);
    if (v > 0) tab[node] = v - 1;
  endfunction

  function automatic logic [STATUS_W-1:0] trie_insert();
    int depth;
    int node;
    int nxt;
    void'(trace_path(depth));
    if (longint'(node_top) + (word_len - depth) > NODES - 1) return STAT_POOL_FULL;
    node = 1;
    bump(pass_cnt, 1);
    for (int i = 0; i < word_len; i++) begin
      nxt = child_at(node, i);
      if (nxt == 0) begin
        node_top++;
        nxt = node_top;
        link_tab[node * ALPHABET + word_buf[i]] = nxt;
      end
      node = nxt;
      bump(pass_cnt, node);
    end
    bump(end_cnt, node);
    return STAT_DONE;
  endfunction

  function automatic void trie_erase();
    int node;
    int nxt;
    if (!word_present()) return;
    node = 1;
    drop(pass_cnt, 1);
    for (int i = 0; i < word_len; i++) begin
      nxt = child_at(node, i);
      if (nxt == 0) return;
      drop(pass_cnt, nxt);
      if (cnt_of(pass_cnt, nxt) == 0) begin
        link_tab.delete(node * ALPHABET + word_buf[i]);
        return;
      end
      node = nxt;
    end
    drop(end_cnt, node);
  endfunction

  // Apply one accepted transaction to the shadow trie
  function automatic void trie_step(input logic [OP_W-1:0] op_i, input int let_i,
                                    input bit has_i, input bit last_i);
    trie_result_t res;
    int depth;
    int node;
    if (has_i) begin
      if (word_len < MAX_WORD) word_buf[word_len] = let_i % ALPHABET;
      if (word_len <= MAX_WORD) word_len++;
    end
    if (!last_i) return;
    res.status = STAT_DONE;
    res.found = 1'b0;
    res.pcount = '0;
    if (word_len > MAX_WORD) begin
      res.status = STAT_TOO_LONG;
      long_refusals++;
    end else begin
      case (op_i)
        OP_INSERT: begin
          res.status = trie_insert();
          if (res.status == STAT_POOL_FULL) pool_refusals++;
        end
        OP_ERASE: trie_erase();
        OP_SEARCH: res.found = word_present();
        OP_PREFIX: begin
          node = trace_path(depth);
          res.pcount = (node != 0) ? PCOUNT_W'(cnt_of(pass_cnt, node)) : '0;
        end
      endcase
    end
    word_len = 0;
    pending_results.push_back(res);
  endfunction

  // Send one transaction; in_stall only moves at the rising edge
  task automatic send_item(input logic [OP_W-1:0] op_i, input int let_i,
                           input bit has_i, input bit last_i);
    bit stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_i;
    letter <= let_i[LETTER_W-1:0];
    has_letter <= has_i;
    last <= last_i;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    trie_step(op_i, let_i, has_i, last_i);
    if (last_i) words_sent++;
  endtask

  // Send a whole word; an empty word is a single item without a letter
  task automatic send_word(input logic [OP_W-1:0] op_i, input int letters[$]);
    if (letters.size() == 0) begin
      send_item(op_i, $urandom_range(31), 1'b0, 1'b1);
    end else begin
      foreach (letters[i]) send_item(op_i, letters[i], 1'b1, i == letters.size() - 1);
    end
  endtask

  // Hold the sender until every expected result is in
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    int w[$];
    w = {};
    send_word(OP_SEARCH, w);
    send_word(OP_INSERT, w);
    send_word(OP_SEARCH, w);
    send_word(OP_PREFIX, w);
    w = {0, 1};
    send_word(OP_INSERT, w);
    send_word(OP_INSERT, w);
    w = {0, 1, 2};
    send_word(OP_INSERT, w);
    w = {0};
    send_word(OP_PREFIX, w);
    send_word(OP_SEARCH, w);
    // erase missing word leaves counts alone
    send_word(OP_ERASE, w);
    w = {0, 1, 2};
    send_word(OP_ERASE, w);
    send_word(OP_SEARCH, w);
    w = {0, 1};
    send_word(OP_PREFIX, w);
    // letters past z wrap around the alphabet
    w = {31, 26, 25};
    send_word(OP_INSERT, w);
    w = {5, 0, 25};
    send_word(OP_SEARCH, w);
    // op of the final item decides; gaps without letters add nothing
    send_item(OP_SEARCH, 0, 1'b1, 1'b0);
    send_item(OP_PREFIX, 17, 1'b0, 1'b0);
    send_item(OP_INSERT, 1, 1'b1, 1'b1);
    // longest accepted word, then one letter too many
    w = {};
    repeat (MAX_WORD) w.push_back(24);
    send_word(OP_INSERT, w);
    send_word(OP_PREFIX, w);
    w.push_back(3);
    send_word(OP_INSERT, w);
    send_word(OP_SEARCH, w);
    send_word(OP_ERASE, w);
    drain();
  endtask

  // Random words over a narrow alphabet so paths collide often
  task automatic test_random(input int idle_pct, input int stall_p, input int n_items);
    int w[$];
    int budget;
    int len;
    int kind;
    logic [OP_W-1:0] word_op;
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    budget = n_items;
    while (budget > 0) begin
      kind = $urandom_range(99);
      word_op = OP_W'($urandom_range(3));
      if (kind < 8) begin
        // malformed: mixed ops, letterless items, wrapping letters
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_item(OP_W'($urandom_range(3)), $urandom_range(31), 1'($urandom_range(1)),
                    i == len - 1);
        budget -= len;
      end else if (kind < 10) begin
        len = $urandom_range(MAX_WORD - 1, MAX_WORD + 3);
        w = {};
        repeat (len) w.push_back($urandom_range(1, 2));
        send_word(word_op, w);
        budget -= len;
      end else begin
        if ($urandom_range(99) < 45) word_op = OP_INSERT;
        len = $urandom_range(0, 5);
        w = {};
        repeat (len) w.push_back($urandom_range(0, 3));
        send_word(word_op, w);
        budget -= (len == 0) ? 1 : len;
      end
    end
    drain();
  endtask

  initial begin
    node_top = 1;
    word_len = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0, 110);
    test_random(71, 0, 110);
    test_random(0, 71, 110);
    test_random(23, 23, 110);
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) report("results never delivered", 0, pending_results.size());
    $display("covered %0d words, %0d results checked, %0d nodes allocated", words_sent,
             results_seen, node_top);
    $display("refusals: %0d too long, %0d node pool full", long_refusals, pool_refusals);
    if (errors == 0) begin
      $display("** prefix_trie_counter: PASSED **");
    end else begin
      $display("** prefix_trie_counter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
